### rtl/core/ubds_pkg.sv
package ubds_pkg;

    // Field widths
    localparam int BAUD_W        = 24;
    localparam int CLK_W         = 32;
    localparam int PRESCALE_BITS = 4;                      // the fixed divide by 16
    localparam int DIVIDEND_W    = CLK_W - PRESCALE_BITS;  // clock / 16
    localparam int QUOT_W        = 15;                     // 256 << 7 saturates here
    localparam int HI_W          = DIVIDEND_W - QUOT_W;    // dividend bits above quotient
    localparam int BRR_W         = 8;
    localparam int TIER_W        = 3;
    localparam int TIER_COUNT    = 8;

    // Pipeline: entry stage, one stage per quotient bit, tier stage
    localparam int PIPE_DEPTH    = QUOT_W + 2;

    localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 32'd60000000;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_SLOW = 2'd1,
        STATUS_BAD_RATE = 2'd2
    } status_t;

    // Partial division state carried down the pipeline
    typedef struct packed {
        status_t             status;
        logic [BAUD_W-1:0]   divisor;
        logic [BAUD_W-1:0]   rem;
        logic [QUOT_W-1:0]   low;
        logic [QUOT_W-1:0]   quot;
    } div_t;

endpackage

### rtl/core/ubds_if.sv
// Request channel: one baud rate per request
interface ubds_req_if;
    logic                        valid;
    logic                        ready;
    logic [ubds_pkg::BAUD_W-1:0] baud_rate;

    modport source (output valid, output baud_rate, input ready);
    modport sink   (input valid, input baud_rate, output ready);
endinterface

// Result channel: divisor settings for one request
interface ubds_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [ubds_pkg::BRR_W-1:0] bit_rate_value;
    logic [1:0]                 clock_select;
    logic                       double_speed;

    modport source (output valid, output status, output bit_rate_value,
                    output clock_select, output double_speed, input ready);
    modport sink   (input valid, input status, input bit_rate_value,
                    input clock_select, input double_speed, output ready);
endinterface

### rtl/core/ubds_front.sv
module ubds_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  logic [ubds_pkg::BAUD_W-1:0]  baud_rate,
    input  logic [ubds_pkg::CLK_W-1:0]   clock_hz,
    output logic                         dn_valid,
    input  logic                         dn_ready,
    output ubds_pkg::div_t               dn_data
);

    logic [ubds_pkg::DIVIDEND_W-1:0] dividend;
    logic [ubds_pkg::HI_W-1:0]       dividend_hi;
    logic                            valid_reg;
    ubds_pkg::div_t                  data_reg;
    ubds_pkg::div_t                  data_next;

    assign dividend    = clock_hz[ubds_pkg::CLK_W-1:ubds_pkg::PRESCALE_BITS];
    assign dividend_hi = dividend[ubds_pkg::DIVIDEND_W-1:ubds_pkg::QUOT_W];

    // Classify and seed the divider; a high part at or above baud is flagged too slow
    always_comb
    begin
        data_next.divisor = baud_rate;
        data_next.rem     = ubds_pkg::BAUD_W'(dividend_hi);
        data_next.low     = dividend[ubds_pkg::QUOT_W-1:0];
        data_next.quot    = '0;
        priority if (baud_rate == '0)
        begin
            data_next.status = ubds_pkg::STATUS_BAD_RATE;
        end
        else if (ubds_pkg::BAUD_W'(dividend_hi) >= baud_rate)
        begin
            data_next.status = ubds_pkg::STATUS_TOO_SLOW;
        end
        else
        begin
            data_next.status = ubds_pkg::STATUS_OK;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### rtl/core/ubds_div_step.sv
module ubds_div_step
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  ubds_pkg::div_t up_data,
    output logic           dn_valid,
    input  logic           dn_ready,
    output ubds_pkg::div_t dn_data
);

    logic [ubds_pkg::BAUD_W:0] trial;
    logic [ubds_pkg::BAUD_W:0] diff;
    logic                      take;
    logic                      valid_reg;
    ubds_pkg::div_t            data_reg;
    ubds_pkg::div_t            data_next;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign trial = {up_data.rem, up_data.low[ubds_pkg::QUOT_W-1]};
    assign diff  = trial - {1'b0, up_data.divisor};
    assign take  = trial >= {1'b0, up_data.divisor};

    always_comb
    begin
        data_next         = up_data;
        data_next.rem     = take ? diff[ubds_pkg::BAUD_W-1:0] : trial[ubds_pkg::BAUD_W-1:0];
        data_next.low     = {up_data.low[ubds_pkg::QUOT_W-2:0], 1'b0};
        data_next.quot    = {up_data.quot[ubds_pkg::QUOT_W-2:0], take};
    end

    assign up_ready = !valid_reg || dn_ready;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### rtl/core/ubds_tier.sv
module ubds_tier
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  ubds_pkg::div_t              up_data,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output logic [1:0]                  status,
    output logic [ubds_pkg::BRR_W-1:0]  bit_rate_value,
    output logic [1:0]                  clock_select,
    output logic                        double_speed
);

    typedef struct packed {
        ubds_pkg::status_t          status;
        logic [ubds_pkg::BRR_W-1:0] brr;
        logic [1:0]                 cks;
        logic                       dbl;
    } res_t;

    logic [ubds_pkg::TIER_W-1:0] tier;
    logic [ubds_pkg::QUOT_W-1:0] scaled;
    logic                        valid_reg;
    res_t                        res_reg;
    res_t                        res_next;

    // Tier = position of the highest quotient bit above the 8-bit field
    always_comb
    begin
        tier = '0;
        for (int i = 0; i < ubds_pkg::TIER_COUNT - 1; i++)
        begin
            if (up_data.quot[ubds_pkg::BRR_W + i])
            begin
                tier = ubds_pkg::TIER_W'(i + 1);
            end
        end
    end

    assign scaled = up_data.quot >> tier;

    // Result fields; any error clears them
    always_comb
    begin
        res_next = '0;
        if (up_data.status != ubds_pkg::STATUS_OK)
        begin
            res_next.status = up_data.status;
        end
        else if (up_data.quot == '0)
        begin
            res_next.status = ubds_pkg::STATUS_BAD_RATE;
        end
        else
        begin
            res_next.status = ubds_pkg::STATUS_OK;
            res_next.brr    = scaled[ubds_pkg::BRR_W-1:0] - ubds_pkg::BRR_W'(1);
            res_next.cks    = tier[ubds_pkg::TIER_W-1:1];
            res_next.dbl    = !tier[0];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign dn_valid       = valid_reg;
    assign status         = res_reg.status;
    assign bit_rate_value = res_reg.brr;
    assign clock_select   = res_reg.cks;
    assign double_speed   = res_reg.dbl;

endmodule

### rtl/core/uart_baud_divisor_select_core.sv
// Serial-unit baud divisor selection.
// request : valid/ready channel carrying baud_rate (bits per second).
// result  : valid/ready channel with status, bit_rate_value, clock_select
//           and double_speed for each request, in request order.
// cfg_write_en/cfg_write_data load the peripheral clock frequency in hertz;
// write it only while no request is in flight.
// The quotient (clock / 16) / baud is formed by a restoring divider with one
// quotient bit per stage: an entry stage, 15 divide stages and a tier/output
// stage, each registered. One request is accepted every cycle while the
// receiver keeps ready high; each stage moves on its own ready, so bubbles
// close up.
// When the receiver stalls, the held result stays on the port and requests
// keep entering until every stage is full; nothing is dropped or repeated.
// Reset empties the pipeline and loads the clock register with 60 MHz.
module uart_baud_divisor_select_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [ubds_pkg::CLK_W-1:0]  cfg_write_data,
    ubds_req_if.sink                    request,
    ubds_rsp_if.source                  result
);

    logic [ubds_pkg::CLK_W-1:0] clock_hz_reg;
    logic                       stage_valid [0:ubds_pkg::QUOT_W];
    logic                       stage_ready [0:ubds_pkg::QUOT_W];
    ubds_pkg::div_t             stage_data  [0:ubds_pkg::QUOT_W];

    // Peripheral clock register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= ubds_pkg::CLOCK_HZ_RESET;
        end
        else if (cfg_write_en)
        begin
            clock_hz_reg <= cfg_write_data;
        end
    end

    // Entry stage: classify and seed the divider
    ubds_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (request.valid),
        .up_ready  (request.ready),
        .baud_rate (request.baud_rate),
        .clock_hz  (clock_hz_reg),
        .dn_valid  (stage_valid[0]),
        .dn_ready  (stage_ready[0]),
        .dn_data   (stage_data[0])
    );

    // Divide stages, one quotient bit each
    for (genvar g = 0; g < ubds_pkg::QUOT_W; g++)
    begin : g_step
        ubds_div_step u_step
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[g]),
            .up_ready (stage_ready[g]),
            .up_data  (stage_data[g]),
            .dn_valid (stage_valid[g+1]),
            .dn_ready (stage_ready[g+1]),
            .dn_data  (stage_data[g+1])
        );
    end

    // Tier selection and output register
    ubds_tier u_tier
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (stage_valid[ubds_pkg::QUOT_W]),
        .up_ready       (stage_ready[ubds_pkg::QUOT_W]),
        .up_data        (stage_data[ubds_pkg::QUOT_W]),
        .dn_valid       (result.valid),
        .dn_ready       (result.ready),
        .status         (result.status),
        .bit_rate_value (result.bit_rate_value),
        .clock_select   (result.clock_select),
        .double_speed   (result.double_speed)
    );

endmodule

### rtl/core/ubds_checker.sv
module ubds_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  logic [1:0]                 rsp_status,
    input  logic [ubds_pkg::BRR_W-1:0] rsp_bit_rate_value,
    input  logic [1:0]                 rsp_clock_select,
    input  logic                       rsp_double_speed
);

    logic       req_fire;
    logic       rsp_fire;
    logic [4:0] pending_reg;
    logic [4:0] pending_next;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Requests accepted and not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (req_fire && !rsp_fire)
        begin
            pending_next = pending_reg + 5'd1;
        end
        else if (!req_fire && rsp_fire)
        begin
            pending_next = pending_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result holds its valid
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result valid dropped while stalled");

    // Every delivered result belongs to an accepted request
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire |-> pending_reg != 5'd0)
        else $error("result with no request outstanding");

    // No more requests in flight than the pipeline holds
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 5'(ubds_pkg::PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    // An error result carries cleared settings
    a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != 2'd0 |->
            rsp_bit_rate_value == '0 && rsp_clock_select == 2'd0 && !rsp_double_speed)
        else $error("error result with nonzero settings");

endmodule

bind uart_baud_divisor_select_core ubds_checker u_ubds_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (request.valid),
    .req_ready          (request.ready),
    .rsp_valid          (result.valid),
    .rsp_ready          (result.ready),
    .rsp_status         (result.status),
    .rsp_bit_rate_value (result.bit_rate_value),
    .rsp_clock_select   (result.clock_select),
    .rsp_double_speed   (result.double_speed)
);
